// ===== design/lcar_pkg.sv =====
// Shared types and constants for the load cell converter reader.
package lcar_pkg;

	localparam int AVG_W     = 24;
	localparam int TARE_W    = 24;
	localparam int SCALE_W   = 32;
	localparam int WEIGHT_W  = 32;
	localparam int COUNT_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_DROP = 8;

	localparam logic signed [TARE_W-1:0]  TARE_RST  = '0;
	localparam logic signed [SCALE_W-1:0] SCALE_RST = 32'sd65536;
	localparam logic [COUNT_W-1:0]        COUNT_RST = 6'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARE,
		CFG_SCALE,
		CFG_COUNT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_HIGH,
		PH_LOW,
		PH_GHIGH,
		PH_GLOW
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic dt_level;
	} item_t;

	typedef struct packed {
		logic                       sck_level;
		logic                       busy_res;
		logic                       done_res;
		logic signed [AVG_W-1:0]    raw_average;
		logic signed [WEIGHT_W-1:0] weight_q8;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/lcar_div.sv =====
// Iterative restoring divider: signed sum by unsigned count, truncating toward zero.
module lcar_div #(
	parameter int SUM_W = 30,
	parameter int CNT_W = 6,
	parameter int Q_W   = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output lcar_pkg::div_stat_t     stat,
	output logic signed [Q_W-1:0]   quotient
);
	import lcar_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  div_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]   trial;
	logic             fits;
	logic [CNT_W:0]   diff;
	logic [SUM_W-1:0] mag;

	assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign quotient = neg_q ? Q_W'(-quo_q) : Q_W'(quo_q);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/lcar_scale.sv =====
// Offset removal, Q16.16 scaling, rounding and saturation to the Q8 weight.
module lcar_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [lcar_pkg::AVG_W-1:0]    avg,
	input  logic signed [lcar_pkg::TARE_W-1:0]   tare,
	input  logic signed [lcar_pkg::SCALE_W-1:0]  scale,
	output logic                                 done,
	output logic signed [lcar_pkg::WEIGHT_W-1:0] weight
);
	import lcar_pkg::*;

	localparam int DIFF_W = AVG_W + 1;
	localparam int PROD_W = DIFF_W + SCALE_W;
	localparam int SH_W   = PROD_W - FRAC_DROP;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_DROP - 1);

	logic                     v_s1, v_s2, done_q;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [WEIGHT_W-1:0] weight_q;

	logic signed [PROD_W-1:0] rnd;
	logic signed [SH_W-1:0]   sh;
	logic [SH_W-WEIGHT_W:0]   hi;
	logic signed [WEIGHT_W-1:0] sat;

	assign rnd = prod_s2 + ROUND_HALF;
	assign sh  = rnd[PROD_W-1:FRAC_DROP];	// floor of the rounded product shifted right by FRAC_DROP
	assign hi  = sh[SH_W-1:WEIGHT_W-1];

	always_comb begin
		if (!hi[SH_W-WEIGHT_W] && (|hi))
			sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
		else if (hi[SH_W-WEIGHT_W] && !(&hi))
			sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
		else
			sat = sh[WEIGHT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			diff_s1 <= DIFF_W'(avg) - DIFF_W'(tare);
		if (v_s1)
			prod_s2 <= diff_s1 * scale;
		if (v_s2)
			weight_q <= sat;
	end

	assign done   = done_q;
	assign weight = weight_q;

endmodule

// ===== design/load_cell_adc_reader_average.sv =====
// Top level: serial converter reader, conversion averaging and weight scaling.
//
// Usage: one item per serial clock half-period. Each item carries the sampled
// data line and a start request; each item gives one result with the clock
// level for the next half-period, busy/done flags and the last average and
// weight. Both channels use valid/stall; the config port (valid/ready, always
// ready) writes tare offset, reciprocal scale and sample count, which the user
// must write only while idle, a duty the block leaves to the user. An ordinary
// item's result is registered at transfer, and a new item is taken every cycle
// while the result side keeps up. The item that completes a measurement runs
// the averaging divider, one quotient bit a cycle over the sum width
// (SAMPLE_BITS + clog2(MAX_SAMPLES) + 1 bits), then three scaling stages, and
// the item side stalls until its result is registered.
// A stalled result holds in the output register; the item side stalls while
// that register is full and not being taken, and during a calculation.
// Reset: clears the sequencer, counters, held average and weight, and loads the
// register defaults (offset 0, scale 1.0, five conversions).
module load_cell_adc_reader_average #(
	parameter int SAMPLE_BITS = 24,
	parameter int MAX_SAMPLES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  lcar_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output lcar_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lcar_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lcar_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lcar_pkg::*;

	localparam int BIT_W = $clog2(SAMPLE_BITS);
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES) + 1;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	// configuration
	logic signed [TARE_W-1:0]  tare_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic [COUNT_W-1:0]        count_q;

	// measurement state
	phase_t                   phase_q, phase_d;
	logic [BIT_W-1:0]         bit_idx_q;
	logic [SAMPLE_BITS-1:0]   shift_q;
	logic [COUNT_W-1:0]       conv_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [AVG_W-1:0]  last_avg_q;
	logic signed [WEIGHT_W-1:0] last_weight_q;
	logic                     calc_busy_q;

	logic      result_valid_q;
	result_t   result_q;

	logic                     accept;
	logic                     last_bit;
	logic [COUNT_W-1:0]       conv_next;
	logic signed [SUM_W-1:0]  sum_next;
	logic [CNT_W-1:0]         eff_cnt;
	logic                     finishing;
	logic                     sck_c;
	logic                     done_c;

	div_stat_t                div_stat;
	logic signed [SAMPLE_BITS-1:0] quotient;
	logic                     scl_done;
	logic signed [WEIGHT_W-1:0] scl_weight;

	assign cfg_ready  = 1'b1;
	assign item_stall = calc_busy_q || (result_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		if (count_q == '0)
			eff_cnt = CNT_W'(1);
		else if (int'(count_q) > MAX_SAMPLES)
			eff_cnt = CNT_W'(MAX_SAMPLES);
		else
			eff_cnt = CNT_W'(count_q);
	end

	assign last_bit  = int'(bit_idx_q) >= SAMPLE_BITS - 1;
	assign conv_next = conv_q + 1'b1;
	assign sum_next  = sum_q + SUM_W'($signed(shift_q));
	assign finishing = int'(conv_next) >= int'(eff_cnt);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_WAIT:  if (!item.dt_level) phase_d = PH_HIGH;
			PH_HIGH:  phase_d = PH_LOW;
			PH_LOW:   phase_d = last_bit ? PH_GHIGH : PH_HIGH;
			PH_GHIGH: phase_d = PH_GLOW;
			PH_GLOW:  phase_d = finishing ? PH_IDLE : PH_WAIT;
			default:  phase_d = item.start_req ? PH_WAIT : PH_IDLE;
		endcase
	end

	always_comb begin
		sck_c  = 1'b0;
		done_c = 1'b0;
		case (phase_q)
			PH_WAIT: sck_c  = !item.dt_level;
			PH_LOW:  sck_c  = 1'b1;
			PH_GLOW: done_c = finishing;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q  <= TARE_RST;
			scale_q <= SCALE_RST;
			count_q <= COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TARE:  tare_q  <= cfg_data[TARE_W-1:0];
				CFG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_idx_q <= '0;
			shift_q   <= '0;
			conv_q    <= '0;
			sum_q     <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_WAIT, PH_HIGH, PH_GHIGH: ;
				PH_LOW: begin
					shift_q <= {shift_q[SAMPLE_BITS-2:0], item.dt_level};
					if (!last_bit)
						bit_idx_q <= bit_idx_q + 1'b1;
				end
				PH_GLOW: begin
					sum_q     <= sum_next;
					conv_q    <= conv_next;
					shift_q   <= '0;
					bit_idx_q <= '0;
				end
				default: begin
					if (item.start_req) begin
						bit_idx_q <= '0;
						shift_q   <= '0;
						conv_q    <= '0;
						sum_q     <= '0;
					end
				end
			endcase
		end
	end

	// the completing transfer hands over to the divider and scaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_busy_q   <= 1'b0;
			last_avg_q    <= '0;
			last_weight_q <= '0;
		end else begin
			if (accept && done_c)
				calc_busy_q <= 1'b1;
			else if (scl_done)
				calc_busy_q <= 1'b0;
			if (div_stat.done)
				last_avg_q <= AVG_W'(quotient);
			if (scl_done)
				last_weight_q <= scl_weight;
		end
	end

	lcar_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W),
		.Q_W  (SAMPLE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && done_c),
		.dividend(sum_next),
		.divisor (eff_cnt),
		.stat    (div_stat),
		.quotient(quotient)
	);

	lcar_scale u_scale (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_stat.done),
		.avg   (AVG_W'(quotient)),
		.tare  (tare_q),
		.scale (scale_q),
		.done  (scl_done),
		.weight(scl_weight)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if ((accept && !done_c) || scl_done)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (scl_done) begin
			result_q.sck_level   <= 1'b0;
			result_q.busy_res    <= 1'b0;
			result_q.done_res    <= 1'b1;
			result_q.raw_average <= last_avg_q;
			result_q.weight_q8   <= scl_weight;
		end else if (accept && !done_c) begin
			result_q.sck_level   <= sck_c;
			result_q.busy_res    <= phase_d != PH_IDLE;
			result_q.done_res    <= 1'b0;
			result_q.raw_average <= last_avg_q;
			result_q.weight_q8   <= last_weight_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_div_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> calc_busy_q)
		else $error("divider finished outside a calculation");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> !result_valid_q)
		else $error("final result would overwrite a pending transfer");

	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done_c) |=> (div_stat.busy && calc_busy_q && !result_valid_q))
		else $error("completing transfer did not start the divider");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.done_res) |-> !result_q.busy_res)
		else $error("done result flagged busy");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the load cell converter reader: bit-level serial read, averaging, scaling.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lcar_pkg::*;

	localparam int     DRAIN_CYCLES   = 40;	// margin for the averaging divide plus scaling
	localparam int     HOLD_CYCLES    = 300;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     TOTAL_ITEMS    = 1350;
	localparam int     MAX_SAMPLES    = 32;
	localparam longint WT_MAX         = 64'sd2147483647;
	localparam longint WT_MIN         = -64'sd2147483648;

	typedef struct {
		item_t   stim;
		bit      known;
		result_t exp;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Reader state as the block should hold it
	phase_t                    rd_phase  = PH_IDLE;
	logic [4:0]                rd_bit    = '0;
	logic [AVG_W-1:0]          rd_shift  = '0;
	logic [COUNT_W-1:0]        rd_conv   = '0;
	longint                    rd_sum    = 0;
	logic signed [AVG_W-1:0]   held_avg  = '0;
	logic signed [WEIGHT_W-1:0] held_wt  = '0;
	logic signed [TARE_W-1:0]  tare_r    = TARE_RST;
	logic signed [SCALE_W-1:0] scale_r   = SCALE_RST;
	logic [COUNT_W-1:0]        count_r   = COUNT_RST;

	result_t          expected_readings [$];
	logic [AVG_W-1:0] word_plan [$];
	logic [AVG_W-1:0] cur_word;
	int               ticks_sent     = 0;
	int               mismatch_count = 0;
	int               reading_index  = 0;
	int               idle_cycles    = 0;
	int               hold_left      = 0;
	bit               quiet          = 1'b0;
	bit               hold_req       = 1'b0;

	// Walk-through of the opening handshake after reset: idle, start, wait, first bits
	dir_row_t dir_rows [14] = '{
		'{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0, 32'sd0}},	// idle, data ignored
		'{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0, 32'sd0}},
		'{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 24'sd0, 32'sd0}},	// start, wait for ready
		'{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 24'sd0, 32'sd0}},
		'{'{1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 24'sd0, 32'sd0}},	// start while busy
		'{'{1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0, 32'sd0}},	// ready: first pulse
		'{'{1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 24'sd0, 32'sd0}},
		'{'{1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0, 32'sd0}},	// MSB sampled
		'{'{1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 24'sd0, 32'sd0}},
		'{'{1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0, 32'sd0}},
		'{'{1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, 1'b1}, 1'b0, '0},
		'{'{1'b0, 1'b0}, 1'b0, '0}
	};

	load_cell_adc_reader_average DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_samples();
		int n;
		n = int'(count_r);
		if (n < 1) n = 1;
		if (n > MAX_SAMPLES) n = MAX_SAMPLES;
		return n;
	endfunction

	// One half-period of the serial sequencer; returns the reading it should produce
	function automatic result_t advance_reader(item_t x);
		result_t r;
		longint  mean;
		longint  w;
		int      n;
		r = '0;
		case (rd_phase)
			PH_WAIT: begin
				if (!x.dt_level) begin
					r.sck_level = 1'b1;
					rd_phase = PH_HIGH;
				end
			end
			PH_HIGH: rd_phase = PH_LOW;
			PH_LOW: begin
				rd_shift = {rd_shift[AVG_W-2:0], x.dt_level};
				r.sck_level = 1'b1;
				if (int'(rd_bit) >= AVG_W - 1) begin
					rd_phase = PH_GHIGH;
				end else begin
					rd_bit = rd_bit + 5'd1;
					rd_phase = PH_HIGH;
				end
			end
			PH_GHIGH: rd_phase = PH_GLOW;
			PH_GLOW: begin
				rd_sum += longint'($signed(rd_shift));
				rd_conv = rd_conv + 6'd1;
				rd_shift = '0;
				rd_bit = '0;
				n = eff_samples();
				if (int'(rd_conv) >= n) begin
					mean = rd_sum / n;	// signed divide truncates toward zero
					w = (mean - longint'(tare_r)) * longint'(scale_r);
					w = (w + 128) >>> FRAC_DROP;	// round half up
					if (w > WT_MAX) w = WT_MAX;
					if (w < WT_MIN) w = WT_MIN;
					held_avg = mean[AVG_W-1:0];
					held_wt = w[WEIGHT_W-1:0];
					r.done_res = 1'b1;
					rd_phase = PH_IDLE;
				end else begin
					rd_phase = PH_WAIT;
				end
			end
			default: begin
				rd_phase = PH_IDLE;
				if (x.start_req) begin
					rd_bit = '0;
					rd_shift = '0;
					rd_conv = '0;
					rd_sum = 0;
					rd_phase = PH_WAIT;
				end
			end
		endcase
		r.busy_res = rd_phase != PH_IDLE;
		r.raw_average = held_avg;
		r.weight_q8 = held_wt;
		return r;
	endfunction

	function automatic logic [AVG_W-1:0] next_word();
		if (word_plan.size() != 0) return word_plan.pop_front();
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(255));
			3: return 24'(-$urandom_range(1, 255));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic tick(input item_t x, input bit known = 1'b0, input result_t typed = '0);
		result_t r;
		while (!quiet && $urandom_range(99) < 26) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (item_stall);
		r = advance_reader(x);
		expected_readings.push_back(known ? typed : r);
		ticks_sent++;
	endtask

	// Drive the line as a converter would until the measurement in flight finishes
	task automatic complete_measurement();
		item_t x;
		bit    was_glow;
		while (rd_phase != PH_IDLE) begin
			x.start_req = 1'($urandom_range(1));
			case (rd_phase)
				PH_WAIT: x.dt_level = $urandom_range(99) < 45;
				PH_LOW:  x.dt_level = cur_word[AVG_W-1-int'(rd_bit)];
				default: x.dt_level = 1'($urandom_range(1));
			endcase
			was_glow = rd_phase == PH_GLOW;
			tick(x);
			if (was_glow && rd_phase == PH_WAIT) cur_word = next_word();
		end
	endtask

	task automatic measure();
		item_t x;
		x.start_req = 1'b1;
		x.dt_level = 1'($urandom_range(1));
		cur_word = next_word();
		tick(x);
		complete_measurement();
		repeat ($urandom_range(0, 3)) begin
			x.start_req = 1'b0;
			x.dt_level = 1'($urandom_range(1));
			tick(x);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [TARE_W-1:0] tare, input logic [SCALE_W-1:0] scale,
			input logic [COUNT_W-1:0] count);
		settle();
		write_reg(CFG_TARE, {{8{tare[TARE_W-1]}}, tare});
		write_reg(CFG_SCALE, scale);
		write_reg(CFG_COUNT, {26'($urandom), count});	// upper bits are don't-care
		cfg_valid <= 1'b0;
		tare_r = tare;
		scale_r = scale;
		count_r = count;
	endtask

	// Receiver: random stalls, a quiet phase and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !quiet && ($urandom_range(99) < 26);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("reading %0d: transfer with nothing expected", reading_index);
			end else begin
				want = expected_readings.pop_front();
				if (result.sck_level !== want.sck_level || result.busy_res !== want.busy_res ||
						result.done_res !== want.done_res ||
						result.raw_average !== want.raw_average ||
						result.weight_q8 !== want.weight_q8) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("reading %0d: expected sck=%0b busy=%0b done=%0b avg=%0d wt=%0d, %s",
							reading_index, want.sck_level, want.busy_res, want.done_res,
							$signed(want.raw_average), $signed(want.weight_q8),
							$sformatf("got sck=%0b busy=%0b done=%0b avg=%0d wt=%0d",
							result.sck_level, result.busy_res, result.done_res,
							$signed(result.raw_average), $signed(result.weight_q8)));
				end
			end
			reading_index++;
		end
	end

	// Watchdog: cycles without any transfer on any channel
	initial begin
		do begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end while (idle_cycles < WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int                  target;
		int                  p;
		logic [TARE_W-1:0]   tare;
		logic [SCALE_W-1:0]  scale;
		logic [COUNT_W-1:0]  count;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) tick(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].exp);
		cur_word = next_word();
		complete_measurement();

		// Extreme words against extreme offsets: saturation in both directions
		configure(24'h7FFFFF, 32'h7FFFFFFF, 6'd1);
		word_plan = '{24'h800000};
		measure();
		configure(24'h800000, 32'h7FFFFFFF, 6'd1);
		word_plan = '{24'h7FFFFF};
		measure();
		// Half-LSB ties round upwards
		configure(24'h000000, 32'd128, 6'd1);
		word_plan = '{24'h000001, 24'hFFFFFF};
		repeat (2) measure();
		// Negative sums divide toward zero
		configure(24'h000000, 32'd65536, 6'd2);
		word_plan = '{24'hFFFFFF, 24'h000000};
		measure();
		// Count of zero acts as one
		configure(24'($urandom), 32'($urandom), 6'd0);
		measure();

		target = TOTAL_ITEMS;
		for (p = 0; ticks_sent < target || p < 4; p++) begin
			case ($urandom_range(7))
				0: tare = 24'h7FFFFF;
				1: tare = 24'h800000;
				2, 3: tare = 24'($urandom_range(2000)) - 24'd1000;
				default: tare = 24'($urandom);
			endcase
			case ($urandom_range(7))
				0: scale = 32'h7FFFFFFF;
				1: scale = 32'h80000000;
				2: scale = 32'd65536;
				3: scale = 32'($urandom_range(1 << 21)) - 32'(1 << 20);
				default: scale = 32'($urandom);
			endcase
			if ($urandom_range(99) < 10)
				count = ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(5, 8));
			else
				count = 6'($urandom_range(1, 4));
			configure(tare, scale, count);
			quiet = p == 1;
			if (p == 3) hold_req = 1'b1;	// sender keeps offering while the results back up
			repeat ($urandom_range(1, 2)) measure();
		end
		quiet = 1'b0;

		settle();
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
